[rtl/core/crclf_pkg.sv]
// ----------------------------------------------------------------------------
// crclf_pkg
// Shared types, codes and the CRC-24 byte update for the line framer.
// ----------------------------------------------------------------------------
package crclf_pkg;

    // CRC-24 polynomial without its implicit top bit
    localparam logic [23:0] CRC_POLY_LOW = 24'h864CFB;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE           = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_LINE = 2'd1;

    // Register reset values
    localparam logic       MODE_RESET           = 1'b1;
    localparam logic [7:0] BYTES_PER_LINE_RESET = 8'd22;

    localparam logic [15:0] LINE_COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_LINE_START = 2'd1,
        KIND_LINE_CRC   = 2'd2,
        KIND_BLOCK_CRC  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] value;
        logic [15:0] line_number;
        logic        last;
    } result_t;

    // One byte through the CRC-24 register, most significant bit first
    function automatic logic [23:0] crc24_byte(input logic [23:0] crc_in,
                                               input logic [7:0]  data);
        logic [23:0] crc;
        crc = crc_in ^ {data, 16'h0000};
        for (int k = 0; k < 8; k++) begin
            if (crc[23]) begin
                crc = {crc[22:0], 1'b0} ^ CRC_POLY_LOW;
            end
            else begin
                crc = {crc[22:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

[rtl/core/crclf_if.sv]
// ----------------------------------------------------------------------------
// crclf_if
// Valid/ready channels of the line framer: byte input, result output and
// configuration writes.
// ----------------------------------------------------------------------------
interface crclf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_block;

    modport source (output valid, output data_byte, output end_of_block, input ready);
    modport sink   (input valid, input data_byte, input end_of_block, output ready);
endinterface

interface crclf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [23:0] value;
    logic [15:0] line_number;
    logic        last;

    modport source (output valid, output kind, output value, output line_number,
                    output last, input ready);
    modport sink   (input valid, input kind, input value, input line_number,
                    input last, output ready);
endinterface

interface crclf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/crc24_line_framer.sv]
// ----------------------------------------------------------------------------
// crc24_line_framer
// Byte framer with a running CRC-24 over all bytes since reset and, in line
// mode, a CRC-24 per line and line-start tokens; every end of block emits CRC words.
// ----------------------------------------------------------------------------
// Output: the first result word of an input word appears in the cycle after
//   the input word is accepted.
// Flow: an input word loads 1 to 3 result words into a 3-entry buffer drained
//   by the single output port; a new word waits until its last word is popped.
// Reset: rst_n clears both CRCs to CRC_INIT_VALUE, the line counters to zero,
//   the registers to line mode with 22 bytes per line, and empties the buffer.
module crc24_line_framer
    import crclf_pkg::*;
#(
    parameter logic [23:0] CRC_INIT_VALUE = 24'hB704CE
) (
    input  logic          clk,
    input  logic          rst_n,
    crclf_in_if.sink      byte_stream,
    crclf_out_if.source   result,
    crclf_cfg_if.sink     cfg
);

    logic        mode_reg;
    logic [7:0]  bytes_per_line_reg;
    logic [23:0] block_crc_reg, block_crc_next;
    logic [23:0] line_crc_reg, line_crc_next;
    logic [15:0] line_count_reg, line_count_next;
    logic [7:0]  position_reg, position_next;

    result_t     slot_reg [3];
    result_t     slot_new [3];
    logic [1:0]  count_reg;
    logic [1:0]  count_new;

    logic        accept;
    logic        pop;

    // Handshakes
    assign cfg.ready         = 1'b1;
    assign byte_stream.ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && result.ready);
    assign accept            = byte_stream.valid && byte_stream.ready;
    assign pop               = result.valid && result.ready;

    assign result.valid       = (count_reg != 2'd0);
    assign result.kind        = slot_reg[0].kind;
    assign result.value       = slot_reg[0].value;
    assign result.line_number = slot_reg[0].line_number;
    assign result.last        = slot_reg[0].last;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_RESET;
            bytes_per_line_reg <= BYTES_PER_LINE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == REG_MODE)
            begin
                mode_reg <= cfg.data[0];
            end
            else if (cfg.index == REG_BYTES_PER_LINE)
            begin
                bytes_per_line_reg <= cfg.data;
            end
        end
    end

    // Work out the result words and the next state for one input word
    always_comb
    begin
        logic [7:0]  b;
        logic [7:0]  len;
        logic [7:0]  pos_inc;
        logic [15:0] line_sat;
        logic [23:0] line_base;
        result_t     r_data;
        result_t     r_lcrc;
        result_t     r_start;

        b         = byte_stream.data_byte;
        len       = (bytes_per_line_reg == 8'd0) ? 8'd1 : bytes_per_line_reg;
        pos_inc   = position_reg + 8'd1;
        line_sat  = (line_count_reg != LINE_COUNT_MAX) ? line_count_reg + 16'd1
                                                       : LINE_COUNT_MAX;
        line_base = (position_reg == 8'd0 && line_count_reg != 16'd0) ? CRC_INIT_VALUE
                                                                     : line_crc_reg;

        r_data  = '{kind: KIND_DATA, value: {16'h0000, b}, line_number: 16'h0000,
                    last: 1'b1};
        r_lcrc  = '{kind: KIND_LINE_CRC, value: line_crc_reg, line_number: 16'h0000,
                    last: 1'b0};
        r_start = '{kind: KIND_LINE_START, value: 24'h000000, line_number: line_sat,
                    last: 1'b0};

        block_crc_next  = block_crc_reg;
        line_crc_next   = line_crc_reg;
        line_count_next = line_count_reg;
        position_next   = position_reg;
        slot_new[0]     = r_data;
        slot_new[1]     = r_data;
        slot_new[2]     = r_data;
        count_new       = 2'd1;

        priority if (!mode_reg && byte_stream.end_of_block)
        begin
            // Raw end of block: three CRC bytes, high first
            slot_new[0] = '{kind: KIND_DATA, value: {16'h0000, block_crc_reg[23:16]},
                            line_number: 16'h0000, last: 1'b0};
            slot_new[1] = '{kind: KIND_DATA, value: {16'h0000, block_crc_reg[15:8]},
                            line_number: 16'h0000, last: 1'b0};
            slot_new[2] = '{kind: KIND_DATA, value: {16'h0000, block_crc_reg[7:0]},
                            line_number: 16'h0000, last: 1'b1};
            count_new   = 2'd3;
        end
        else if (!mode_reg)
        begin
            // Raw byte: pass through
            block_crc_next = crc24_byte(block_crc_reg, b);
        end
        else if (byte_stream.end_of_block)
        begin
            // Line end of block: line CRC, then block CRC with next line number
            slot_new[0] = r_lcrc;
            slot_new[1] = '{kind: KIND_BLOCK_CRC, value: block_crc_reg,
                            line_number: line_sat, last: 1'b1};
            count_new   = 2'd2;
        end
        else
        begin
            // Line byte: optional line close and line start before the byte
            block_crc_next = crc24_byte(block_crc_reg, b);
            line_crc_next  = crc24_byte(line_base, b);
            position_next  = (pos_inc >= len) ? 8'd0 : pos_inc;
            if (position_reg == 8'd0)
            begin
                line_count_next = line_sat;
                if (line_count_reg != 16'd0)
                begin
                    slot_new[0] = r_lcrc;
                    slot_new[1] = r_start;
                    count_new   = 2'd3;
                end
                else
                begin
                    slot_new[0] = r_start;
                    count_new   = 2'd2;
                end
            end
        end
    end

    // Framer state: advance on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_crc_reg  <= CRC_INIT_VALUE;
            line_crc_reg   <= CRC_INIT_VALUE;
            line_count_reg <= 16'd0;
            position_reg   <= 8'd0;
        end
        else if (accept)
        begin
            block_crc_reg  <= block_crc_next;
            line_crc_reg   <= line_crc_next;
            line_count_reg <= line_count_next;
            position_reg   <= position_next;
        end
    end

    // Result buffer fill count: load on accept, drop one on each pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (accept)
        begin
            count_reg <= count_new;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // Result buffer payload: load on accept, shift toward the head on pop
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[0] <= slot_new[0];
            slot_reg[1] <= slot_new[1];
            slot_reg[2] <= slot_new[2];
        end
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    // Checks
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg != 2'd0))
        else $error("accepted word left the result buffer empty");

    a_last_is_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.last) |-> (count_reg == 2'd1))
        else $error("last word shown while more results are buffered");

    a_line_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (line_count_reg >= $past(line_count_reg)))
        else $error("line count went down");

    a_crc_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(block_crc_reg))
        else $error("block CRC changed without an accepted word");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crc24_line_framer. A driver feeds byte words and
// end-of-block words from a stimulus queue. Register writes happen only once
// the framer has drained. A built-in predictor of the block CRC, line CRC and
// line counter builds the expected result words. A monitor compares every
// accepted result word with the oldest prediction. Both sides idle in random
// bursts, and the receiver once holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;
    import crclf_pkg::*;

    localparam logic [23:0] CRC_SEED         = 24'hB704CE;
    localparam int          SETTLE_CYCLES    = 4;
    localparam int          DRAIN_CYCLES     = 10;
    localparam int          HOLD_AFTER_WORDS = 150;
    localparam int          HOLD_CYCLES      = 300;
    localparam int          CYCLE_LIMIT      = 100000;
    localparam int          RANDOM_PHASES    = 9;
    localparam int          TAIL_LINE_WORDS  = 20;

    // Register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        OP_WORD,
        OP_DRAIN,
        OP_CFG
    } stim_kind_t;

    typedef struct packed {
        stim_kind_t           op;
        logic [CFG_INDEX_W-1:0] index;
        logic [7:0]           data;
        logic                 eob;
    } stim_op_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    crclf_in_if  byte_if ();
    crclf_out_if res_if ();
    crclf_cfg_if cfg_if ();

    crc24_line_framer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_if),
        .result      (res_if),
        .cfg         (cfg_if)
    );

    // Stimulus and expectations
    stim_op_t stim_q [$];
    result_t  expected_words [$];

    // Predictor state and registers
    logic        p_mode;
    logic [7:0]  p_line_len;
    logic [23:0] p_block_crc;
    logic [23:0] p_line_crc;
    logic [15:0] p_line_count;
    logic [7:0]  p_line_pos;

    // Bookkeeping
    int   words_sent    = 0;
    int   words_left    = 0;
    int   tail_words    = 0;
    int   results_seen  = 0;
    int   cfg_writes    = 0;
    int   errors        = 0;
    int   cycle_count   = 0;
    int   gap_cnt       = 0;
    int   settle_cnt    = 0;
    int   stall_cnt     = 0;
    int   hold_cycles   = 0;
    logic hold_done     = 1'b0;
    logic in_next_valid;
    logic cfg_next_valid;
    stim_op_t cur_op;
    result_t  exp_word;

    logic quiet_tail;
    logic send_idle_ok;
    logic recv_idle_ok;

    assign quiet_tail   = (words_left <= tail_words);
    assign send_idle_ok = !quiet_tail && (words_sent[6:5] != 2'b11);
    assign recv_idle_ok = !quiet_tail && (results_seen[7:6] != 2'b11);

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // CRC-24, one data bit at a time, most significant bit first
    function automatic logic [23:0] crc24_step(input logic [23:0] crc,
                                               input logic [7:0]  data);
        logic [23:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[23] ^ data[i];
            r  = {r[22:0], 1'b0};
            if (fb)
            begin
                r = r ^ CRC_POLY_LOW;
            end
        end
        return r;
    endfunction

    function automatic result_t make_word(input kind_t k, input logic [23:0] v,
                                          input logic [15:0] ln);
        result_t r;
        r.kind        = k;
        r.value       = v;
        r.line_number = ln;
        r.last        = 1'b0;
        return r;
    endfunction

    // Work out the result words of one accepted input word
    task automatic predict_frame_words(input logic [7:0] b, input logic eob);
        result_t     words [3];
        int          n;
        logic [7:0]  len;
        logic [15:0] next_line;
        n         = 0;
        len       = (p_line_len == 8'd0) ? 8'd1 : p_line_len;
        next_line = (p_line_count != LINE_COUNT_MAX) ? p_line_count + 16'd1
                                                     : LINE_COUNT_MAX;
        if (!p_mode)
        begin
            if (eob)
            begin
                words[0] = make_word(KIND_DATA, {16'h0, p_block_crc[23:16]}, 16'h0);
                words[1] = make_word(KIND_DATA, {16'h0, p_block_crc[15:8]}, 16'h0);
                words[2] = make_word(KIND_DATA, {16'h0, p_block_crc[7:0]}, 16'h0);
                n = 3;
            end
            else
            begin
                p_block_crc = crc24_step(p_block_crc, b);
                words[0]    = make_word(KIND_DATA, {16'h0, b}, 16'h0);
                n = 1;
            end
        end
        else if (eob)
        begin
            words[0] = make_word(KIND_LINE_CRC, p_line_crc, 16'h0);
            words[1] = make_word(KIND_BLOCK_CRC, p_block_crc, next_line);
            n = 2;
        end
        else
        begin
            p_block_crc = crc24_step(p_block_crc, b);
            // Close the previous line and open a new one
            if (p_line_pos == 8'd0)
            begin
                if (p_line_count != 16'd0)
                begin
                    words[n]   = make_word(KIND_LINE_CRC, p_line_crc, 16'h0);
                    n++;
                    p_line_crc = CRC_SEED;
                end
                p_line_count = next_line;
                words[n]     = make_word(KIND_LINE_START, 24'h0, p_line_count);
                n++;
            end
            words[n]   = make_word(KIND_DATA, {16'h0, b}, 16'h0);
            n++;
            p_line_crc = crc24_step(p_line_crc, b);
            p_line_pos = p_line_pos + 8'd1;
            if (p_line_pos >= len)
            begin
                p_line_pos = 8'd0;
            end
        end
        words[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
        begin
            expected_words.push_back(words[k]);
        end
    endtask

    task automatic add_word(input logic [7:0] b, input logic eob);
        stim_op_t op;
        op.op    = OP_WORD;
        op.index = REG_MODE;
        op.data  = b;
        op.eob   = eob;
        stim_q.push_back(op);
        words_left++;
    endtask

    // Drain the framer, then write one register
    task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        stim_op_t op;
        op.op    = OP_DRAIN;
        op.index = idx;
        op.data  = val;
        op.eob   = 1'b0;
        stim_q.push_back(op);
        op.op    = OP_CFG;
        stim_q.push_back(op);
    endtask

    // Driver: byte words and register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_if.valid        <= 1'b0;
            byte_if.data_byte    <= 8'h00;
            byte_if.end_of_block <= 1'b0;
            cfg_if.valid         <= 1'b0;
            cfg_if.index         <= REG_MODE;
            cfg_if.data          <= 8'h00;
        end
        else
        begin
            in_next_valid  = byte_if.valid;
            cfg_next_valid = cfg_if.valid;
            // Retire the accepted word and predict its results
            if (byte_if.valid && byte_if.ready)
            begin
                predict_frame_words(byte_if.data_byte, byte_if.end_of_block);
                words_sent    <= words_sent + 1;
                in_next_valid  = 1'b0;
                if (send_idle_ok && $urandom_range(0, 3) == 0)
                begin
                    gap_cnt = $urandom_range(1, 17);
                end
            end
            // Apply the accepted register write
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.index)
                    REG_MODE:           p_mode     = cfg_if.data[0];
                    REG_BYTES_PER_LINE: p_line_len = cfg_if.data;
                    default:            ;
                endcase
                cfg_writes++;
                cfg_next_valid = 1'b0;
            end
            // Pick the next operation
            if (!in_next_valid && !cfg_next_valid)
            begin
                if (settle_cnt > 0)
                begin
                    settle_cnt--;
                end
                else if (gap_cnt > 0)
                begin
                    gap_cnt--;
                end
                else if (stim_q.size() > 0)
                begin
                    cur_op = stim_q[0];
                    case (cur_op.op)
                        OP_WORD:
                        begin
                            byte_if.data_byte    <= cur_op.data;
                            byte_if.end_of_block <= cur_op.eob;
                            in_next_valid         = 1'b1;
                            words_left--;
                            void'(stim_q.pop_front());
                        end
                        OP_DRAIN:
                        begin
                            if (expected_words.size() == 0)
                            begin
                                settle_cnt = SETTLE_CYCLES;
                                void'(stim_q.pop_front());
                            end
                        end
                        OP_CFG:
                        begin
                            cfg_if.index   <= cur_op.index;
                            cfg_if.data    <= cur_op.data;
                            cfg_next_valid  = 1'b1;
                            void'(stim_q.pop_front());
                        end
                        default:
                        begin
                            void'(stim_q.pop_front());
                        end
                    endcase
                end
            end
            byte_if.valid <= in_next_valid;
            cfg_if.valid  <= cfg_next_valid;
        end
    end

    // Long receiver hold-off so the result buffer fills and the input stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end
        else if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
        end
        else if (!hold_done && words_sent >= HOLD_AFTER_WORDS)
        begin
            hold_cycles <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end
    end

    // Monitor: check result words and drive ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                results_seen++;
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word, got kind %0d value %h line %0d last %b",
                             $time, res_if.kind, res_if.value, res_if.line_number,
                             res_if.last);
                end
                else
                begin
                    exp_word = expected_words.pop_front();
                    if (res_if.kind !== exp_word.kind
                        || res_if.value !== exp_word.value
                        || res_if.line_number !== exp_word.line_number
                        || res_if.last !== exp_word.last)
                    begin
                        errors++;
                        $display("%0t: mismatch, expected kind %0d value %h line %0d last %b",
                                 $time, exp_word.kind, exp_word.value,
                                 exp_word.line_number, exp_word.last);
                        $display("%0t:           actual kind %0d value %h line %0d last %b",
                                 $time, res_if.kind, res_if.value, res_if.line_number,
                                 res_if.last);
                    end
                end
            end
            // Stall in bursts, and drop ready through the long hold-off
            if (hold_cycles != 0)
            begin
                res_if.ready <= 1'b0;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (recv_idle_ok && $urandom_range(0, 4) == 0)
                begin
                    stall_cnt = $urandom_range(1, 17);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : main
        logic [7:0] line_len_plan [RANDOM_PHASES];
        logic [7:0] cfg_val;
        int         n_words;
        int         tail_mark;

        byte_if.valid        = 1'b0;
        byte_if.data_byte    = 8'h00;
        byte_if.end_of_block = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = REG_MODE;
        cfg_if.data          = 8'h00;
        res_if.ready         = 1'b0;

        p_mode       = MODE_RESET;
        p_line_len   = BYTES_PER_LINE_RESET;
        p_block_crc  = CRC_SEED;
        p_line_crc   = CRC_SEED;
        p_line_count = 16'd0;
        p_line_pos   = 8'd0;

        // Reset values: line mode, first line, extremes of the byte
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'h55, 1'b0);
        add_word(8'hAA, 1'b0);
        add_word(8'hC3, 1'b1);
        // A second end of block repeats the CRC words
        add_word(8'h3C, 1'b1);

        // Raw mode in the middle of the block, line state untouched
        add_cfg(REG_MODE, 8'h00);
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'h00, 1'b1);
        add_word(8'hFF, 1'b1);

        // Back to line mode with a zero line length, which acts as one
        add_cfg(REG_MODE, 8'hFF);
        add_cfg(REG_BYTES_PER_LINE, 8'h00);
        add_word(8'h12, 1'b0);
        add_word(8'h34, 1'b0);
        add_word(8'h56, 1'b0);
        add_word(8'h00, 1'b1);

        // Longest line, then shorten it in the middle of a line
        add_cfg(REG_BYTES_PER_LINE, 8'hFF);
        add_word(8'h01, 1'b0);
        add_word(8'h80, 1'b0);
        add_word(8'h7F, 1'b0);
        add_cfg(REG_BYTES_PER_LINE, 8'd1);
        add_cfg(REG_SPARE_A, 8'hFF);
        add_cfg(REG_SPARE_B, 8'h00);
        add_word(8'hFE, 1'b0);
        add_word(8'h02, 1'b0);
        add_word(8'h00, 1'b1);

        // Random phases: blocks of random bytes under changing settings
        line_len_plan[0] = 8'd1;
        line_len_plan[1] = 8'd255;
        line_len_plan[2] = 8'd5;
        line_len_plan[3] = 8'd0;
        line_len_plan[4] = 8'd2;
        line_len_plan[5] = 8'd22;
        line_len_plan[6] = 8'($urandom_range(1, 40));
        line_len_plan[7] = 8'd3;
        line_len_plan[8] = 8'd128;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            cfg_val    = 8'($urandom);
            cfg_val[0] = (ph % 3 == 1) ? 1'b0 : 1'b1;
            add_cfg(REG_MODE, cfg_val);
            add_cfg(REG_BYTES_PER_LINE, line_len_plan[ph]);
            n_words = $urandom_range(26, 34);
            for (int k = 0; k < n_words; k++)
            begin
                add_word(8'($urandom), ($urandom_range(0, 11) == 0));
            end
            add_word(8'($urandom), 1'b1);
        end

        // Quiet tail: a run of one-byte lines ending a block, then one short block
        tail_mark = words_left;
        add_cfg(REG_MODE, 8'h01);
        add_cfg(REG_BYTES_PER_LINE, 8'd1);
        for (int k = 0; k < TAIL_LINE_WORDS; k++)
        begin
            add_word(8'($urandom), 1'b0);
        end
        add_word(8'h00, 1'b1);
        add_word(8'hA5, 1'b0);
        add_word(8'h5A, 1'b0);
        add_word(8'hFF, 1'b1);
        tail_words = words_left - tail_mark;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all stimulus, then for the last results
        while (stim_q.size() != 0 || byte_if.valid || cfg_if.valid)
        begin
            @(posedge clk);
        end
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input words, %0d result words and %0d register writes,",
                 words_sent, results_seen, cfg_writes);
        $display("raw and line mode, line lengths 0 to 255, line counter at %0d.",
                 p_line_count);
        if (errors == 0 && expected_words.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[crc24_line_framer.f]
rtl/core/crclf_pkg.sv
rtl/core/crclf_if.sv
rtl/core/crc24_line_framer.sv
bench/tb.sv
